// ----- sv/mlqs_pkg.sv -----
// Package for the multilevel queue scheduler: word types, constants and commands.
// Used by mlqs_datapath, mlqs_ctrl and multilevel_queue_scheduler.
package mlqs_pkg;

   localparam int MaxProcsDefault  = 8;
   localparam int NumLevelsDefault = 3;

   // Command codes of the request word.
   localparam logic CmdLoad = 1'b0;
   localparam logic CmdTick = 1'b1;

   typedef struct packed {
      logic        command;
      logic [1:0]  level;
      logic [7:0]  proc_id;
      logic [15:0] arrival;
      logic [15:0] burst_total;
      logic [7:0]  cpu_burst_len;
      logic [7:0]  io_len;
      logic [7:0]  slice;
   } req_word_type;

   typedef struct packed {
      logic        load_rejected;
      logic        running_valid;
      logic [7:0]  running_id;
      logic        finish_valid;
      logic [7:0]  finish_id;
      logic [15:0] turnaround;
      logic [15:0] response;
      logic [15:0] waiting;
      logic [15:0] context_switches;
   } rsp_word_type;

   // Operations the controller asks of the datapath, one per cycle.
   typedef enum logic [2:0] {
      OpNone,
      OpLoad,
      OpAdvance,
      OpAdmit,
      OpRetire,
      OpIoReturn,
      OpDispatch,
      OpFinish
   } op_type;

   typedef struct packed {
      op_type op;
      logic   clear_result;
   } cmd_type;

   typedef struct packed {
      logic admit_last;
   } status_type;

endpackage

// ----- sv/mlqs_datapath.sv -----
// Datapath of the multilevel queue scheduler: process table, ready and I/O queues.
// Depends on mlqs_pkg; driven by mlqs_ctrl through cmd_type and status_type.
module mlqs_datapath #(
   parameter int MAX_PROCS  = mlqs_pkg::MaxProcsDefault,
   parameter int NUM_LEVELS = mlqs_pkg::NumLevelsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mlqs_pkg::req_word_type req_word,
   input  mlqs_pkg::cmd_type      cmd,
   output mlqs_pkg::status_type   status,
   output mlqs_pkg::rsp_word_type result
);

   localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam logic [LW-1:0] TopLevel = LW'(NUM_LEVELS - 1);

   typedef logic [SW-1:0] slot_type;
   typedef logic [CW-1:0] cnt_type;

   // Process table, one row per slot.
   logic [LW-1:0] lvl_ff   [MAX_PROCS];
   logic [7:0]    id_ff    [MAX_PROCS];
   logic [15:0]   arr_ff   [MAX_PROCS];
   logic [15:0]   tot_ff   [MAX_PROCS];
   logic [7:0]    cpul_ff  [MAX_PROCS];
   logic [7:0]    iol_ff   [MAX_PROCS];
   logic [7:0]    slc_ff   [MAX_PROCS];
   logic          arrd_ff  [MAX_PROCS];
   logic          strt_ff  [MAX_PROCS];
   logic [15:0]   resp_ff  [MAX_PROCS];
   logic [15:0]   exe_ff   [MAX_PROCS];
   logic [7:0]    brun_ff  [MAX_PROCS];
   logic [7:0]    iorun_ff [MAX_PROCS];
   logic [7:0]    srun_ff  [MAX_PROCS];

   // Ready queues and the I/O queue.
   slot_type rq_ff   [NUM_LEVELS][MAX_PROCS];
   slot_type rqh_ff  [NUM_LEVELS];
   cnt_type  rqc_ff  [NUM_LEVELS];
   slot_type ioq_ff  [MAX_PROCS];
   slot_type ioh_ff;
   cnt_type  ioc_ff;

   logic [15:0] time_ff;
   cnt_type     pcount_ff;
   logic        busy_ff;
   slot_type    cslot_ff;
   logic [15:0] disp_ff;
   slot_type    scan_ff;
   mlqs_pkg::rsp_word_type res_ff;

   slot_type cs;
   slot_type ioslot;
   logic [LW-1:0] ld_lvl;
   logic [15:0] tt;
   logic [LW-1:0] pick_lvl;
   logic pick_ok;
   logic [15:0] nz_tot;
   logic [7:0] nz_cpu, nz_io, nz_slc;

   function automatic slot_type wrap_add(slot_type h, cnt_type c);
      logic [SW:0] s;
      s = {1'b0, h} + (SW+1)'(c);
      if (s >= (SW+1)'(MAX_PROCS)) begin
         s = s - (SW+1)'(MAX_PROCS);
      end
      return s[SW-1:0];
   endfunction

   // Combinational selections for the current step.
   always_comb begin
      cs     = cslot_ff;
      ioslot = ioq_ff[ioh_ff];
      ld_lvl = (req_word.level >= 2'(NUM_LEVELS)) ? TopLevel : LW'(req_word.level);
      nz_tot = (req_word.burst_total == 16'd0) ? 16'd1 : req_word.burst_total;
      nz_cpu = (req_word.cpu_burst_len == 8'd0) ? 8'd1 : req_word.cpu_burst_len;
      nz_io  = (req_word.io_len == 8'd0) ? 8'd1 : req_word.io_len;
      nz_slc = (req_word.slice == 8'd0) ? 8'd1 : req_word.slice;
      tt = (time_ff >= arr_ff[cs]) ? time_ff - arr_ff[cs] : 16'd0;
      pick_ok  = 1'b0;
      pick_lvl = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (rqc_ff[l] != '0) begin
            pick_ok  = 1'b1;
            pick_lvl = LW'(l);
         end
      end
      status.admit_last = ({1'b0, scan_ff} + 1'b1 >= (SW+1)'(pcount_ff))
                          || (32'(scan_ff) == MAX_PROCS - 1);
   end

   // One load or one step of the tick sequence per cycle, as commanded.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff   <= '0;
         pcount_ff <= '0;
         busy_ff   <= 1'b0;
         cslot_ff  <= '0;
         disp_ff   <= '0;
         scan_ff   <= '0;
         ioh_ff    <= '0;
         ioc_ff    <= '0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            rqh_ff[l] <= '0;
            rqc_ff[l] <= '0;
         end
         res_ff <= '0;
      end else begin
         // A load into a full table is flagged as the result is cleared.
         if (cmd.clear_result) begin
            res_ff.load_rejected <= (cmd.op == mlqs_pkg::OpLoad)
                                    && (pcount_ff >= CW'(MAX_PROCS));
            res_ff.finish_valid  <= 1'b0;
            res_ff.finish_id     <= '0;
            res_ff.turnaround    <= '0;
            res_ff.response      <= '0;
            res_ff.waiting       <= '0;
            scan_ff              <= '0;
         end
         case (cmd.op)
            mlqs_pkg::OpLoad: begin
               if (pcount_ff < CW'(MAX_PROCS)) begin
                  lvl_ff[pcount_ff[SW-1:0]]  <= ld_lvl;
                  id_ff[pcount_ff[SW-1:0]]   <= req_word.proc_id;
                  arr_ff[pcount_ff[SW-1:0]]  <= req_word.arrival;
                  tot_ff[pcount_ff[SW-1:0]]  <= nz_tot;
                  cpul_ff[pcount_ff[SW-1:0]] <= nz_cpu;
                  iol_ff[pcount_ff[SW-1:0]]  <= nz_io;
                  slc_ff[pcount_ff[SW-1:0]]  <= nz_slc;
                  arrd_ff[pcount_ff[SW-1:0]] <= 1'b0;
                  strt_ff[pcount_ff[SW-1:0]] <= 1'b0;
                  resp_ff[pcount_ff[SW-1:0]] <= '0;
                  exe_ff[pcount_ff[SW-1:0]]  <= '0;
                  brun_ff[pcount_ff[SW-1:0]] <= '0;
                  iorun_ff[pcount_ff[SW-1:0]] <= '0;
                  srun_ff[pcount_ff[SW-1:0]] <= '0;
                  pcount_ff <= pcount_ff + 1'b1;
               end
            end
            mlqs_pkg::OpAdvance: begin
               if (busy_ff) begin
                  exe_ff[cs]  <= exe_ff[cs] + 16'd1;
                  brun_ff[cs] <= brun_ff[cs] + 8'd1;
                  srun_ff[cs] <= srun_ff[cs] + 8'd1;
               end
               if (ioc_ff != '0) begin
                  iorun_ff[ioslot] <= iorun_ff[ioslot] + 8'd1;
               end
            end
            mlqs_pkg::OpAdmit: begin
               // One table row is examined per cycle, in load order.
               if (CW'(scan_ff) < pcount_ff && !arrd_ff[scan_ff]
                   && arr_ff[scan_ff] <= time_ff) begin
                  arrd_ff[scan_ff] <= 1'b1;
                  if (rqc_ff[lvl_ff[scan_ff]] < CW'(MAX_PROCS)) begin
                     rq_ff[lvl_ff[scan_ff]][wrap_add(rqh_ff[lvl_ff[scan_ff]],
                        rqc_ff[lvl_ff[scan_ff]])] <= scan_ff;
                     rqc_ff[lvl_ff[scan_ff]] <= rqc_ff[lvl_ff[scan_ff]] + 1'b1;
                  end
               end
               scan_ff <= scan_ff + 1'b1;
            end
            mlqs_pkg::OpRetire: begin
               if (busy_ff) begin
                  if (exe_ff[cs] == tot_ff[cs]) begin
                     res_ff.finish_valid <= 1'b1;
                     res_ff.finish_id    <= id_ff[cs];
                     res_ff.turnaround   <= tt;
                     res_ff.response     <= resp_ff[cs];
                     res_ff.waiting      <= (tt >= tot_ff[cs]) ? tt - tot_ff[cs] : 16'd0;
                     busy_ff <= 1'b0;
                  end else if (brun_ff[cs] == cpul_ff[cs]) begin
                     brun_ff[cs]  <= '0;
                     iorun_ff[cs] <= '0;
                     srun_ff[cs]  <= '0;
                     if (ioc_ff < CW'(MAX_PROCS)) begin
                        ioq_ff[wrap_add(ioh_ff, ioc_ff)] <= cs;
                        ioc_ff <= ioc_ff + 1'b1;
                     end
                     busy_ff <= 1'b0;
                  end else if (srun_ff[cs] == slc_ff[cs]) begin
                     srun_ff[cs] <= '0;
                     if (rqc_ff[lvl_ff[cs]] < CW'(MAX_PROCS)) begin
                        rq_ff[lvl_ff[cs]][wrap_add(rqh_ff[lvl_ff[cs]],
                           rqc_ff[lvl_ff[cs]])] <= cs;
                        rqc_ff[lvl_ff[cs]] <= rqc_ff[lvl_ff[cs]] + 1'b1;
                     end
                     busy_ff <= 1'b0;
                  end
               end
            end
            mlqs_pkg::OpIoReturn: begin
               if (ioc_ff != '0 && iorun_ff[ioslot] == iol_ff[ioslot]) begin
                  brun_ff[ioslot] <= '0;
                  srun_ff[ioslot] <= '0;
                  ioh_ff <= wrap_add(ioh_ff, CW'(1));
                  ioc_ff <= ioc_ff - 1'b1;
                  if (rqc_ff[lvl_ff[ioslot]] < CW'(MAX_PROCS)) begin
                     rq_ff[lvl_ff[ioslot]][wrap_add(rqh_ff[lvl_ff[ioslot]],
                        rqc_ff[lvl_ff[ioslot]])] <= ioslot;
                     rqc_ff[lvl_ff[ioslot]] <= rqc_ff[lvl_ff[ioslot]] + 1'b1;
                  end
               end
            end
            mlqs_pkg::OpDispatch: begin
               if (!busy_ff && pick_ok) begin
                  busy_ff  <= 1'b1;
                  cslot_ff <= rq_ff[pick_lvl][rqh_ff[pick_lvl]];
                  rqh_ff[pick_lvl] <= wrap_add(rqh_ff[pick_lvl], CW'(1));
                  rqc_ff[pick_lvl] <= rqc_ff[pick_lvl] - 1'b1;
                  if (disp_ff != 16'hFFFF) begin
                     disp_ff <= disp_ff + 16'd1;
                  end
                  if (!strt_ff[rq_ff[pick_lvl][rqh_ff[pick_lvl]]]) begin
                     strt_ff[rq_ff[pick_lvl][rqh_ff[pick_lvl]]] <= 1'b1;
                     resp_ff[rq_ff[pick_lvl][rqh_ff[pick_lvl]]] <=
                        (time_ff >= arr_ff[rq_ff[pick_lvl][rqh_ff[pick_lvl]]]) ?
                        time_ff - arr_ff[rq_ff[pick_lvl][rqh_ff[pick_lvl]]] : 16'd0;
                  end
               end
               if (time_ff != 16'hFFFF) begin
                  time_ff <= time_ff + 16'd1;
               end
            end
            mlqs_pkg::OpFinish: begin
               res_ff.running_valid    <= busy_ff;
               res_ff.running_id       <= busy_ff ? id_ff[cs] : 8'd0;
               res_ff.context_switches <= (disp_ff != 16'd0) ? disp_ff - 16'd1 : 16'd0;
            end
            default: begin
            end
         endcase
      end
   end

   assign result = res_ff;

endmodule

// ----- sv/mlqs_ctrl.sv -----
// Controller of the multilevel queue scheduler: handshakes and step sequencing.
// Depends on mlqs_pkg; commands mlqs_datapath.
module mlqs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mlqs_pkg::status_type status,
   output mlqs_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      StIdle, StAdvance, StAdmit, StRetire, StIoReturn, StDispatch, StFinish, StOut
   } state_type;

   state_type state_ff;
   logic      valid_ff;

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = valid_ff;

   // Command decode for the current state.
   always_comb begin
      cmd.clear_result = 1'b0;
      cmd.op = mlqs_pkg::OpNone;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.clear_result = 1'b1;
               cmd.op = (req_command == mlqs_pkg::CmdLoad) ? mlqs_pkg::OpLoad
                                                            : mlqs_pkg::OpNone;
            end
         end
         StAdvance:  cmd.op = mlqs_pkg::OpAdvance;
         StAdmit:    cmd.op = mlqs_pkg::OpAdmit;
         StRetire:   cmd.op = mlqs_pkg::OpRetire;
         StIoReturn: cmd.op = mlqs_pkg::OpIoReturn;
         StDispatch: cmd.op = mlqs_pkg::OpDispatch;
         StFinish:   cmd.op = mlqs_pkg::OpFinish;
         default:    cmd.op = mlqs_pkg::OpNone;
      endcase
   end

   // State register and the registered response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            StIdle: begin
               if (req_valid) begin
                  state_ff <= (req_command == mlqs_pkg::CmdTick) ? StAdvance : StFinish;
               end
            end
            StAdvance:  state_ff <= StAdmit;
            StAdmit:    state_ff <= status.admit_last ? StRetire : StAdmit;
            StRetire:   state_ff <= StIoReturn;
            StIoReturn: state_ff <= StDispatch;
            StDispatch: state_ff <= StFinish;
            StFinish: begin
               state_ff <= StOut;
               valid_ff <= 1'b1;
            end
            StOut: begin
               if (rsp_ready) begin
                  valid_ff <= 1'b0;
                  state_ff <= StIdle;
               end
            end
            default: state_ff <= StIdle;
         endcase
      end
   end

endmodule

// ----- sv/multilevel_queue_scheduler.sv -----
// Top level of the multilevel queue scheduler.
// Depends on mlqs_pkg, mlqs_ctrl and mlqs_datapath.
//
//   Channel | Ports                          | Direction
//   request | req_valid, req_ready, req_word | in
//   result  | rsp_valid, rsp_ready, rsp_word | out
//
// A load word goes from the idle state through the finish state to the output state, where its result is shown.
// A tick steps through the advance, admission, retire, I/O return, dispatch and finish states;
// the admission scan visits one table row per cycle, over the loaded rows (at least one, at most MAX_PROCS).
// Reset is synchronous and clears all control state; table rows hold garbage until loaded.
// A result that is not taken holds the block; no new word is accepted until it goes.
module multilevel_queue_scheduler #(
   parameter int MAX_PROCS  = mlqs_pkg::MaxProcsDefault,
   parameter int NUM_LEVELS = mlqs_pkg::NumLevelsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mlqs_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mlqs_pkg::rsp_word_type rsp_word
);

   mlqs_pkg::cmd_type    cmd;
   mlqs_pkg::status_type status;

   mlqs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_word.command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   mlqs_datapath #(
      .MAX_PROCS  (MAX_PROCS),
      .NUM_LEVELS (NUM_LEVELS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .result   (rsp_word)
   );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for multilevel_queue_scheduler: load and tick words are
// driven in random bursts and every result word is checked against a local scheduler model.
// Depends on mlqs_pkg and the multilevel_queue_scheduler RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int NumSlots  = 8;
   localparam int NumLevels = 3;
   localparam int IdleLimit = 20000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   mlqs_pkg::req_word_type req_word;
   logic                   rsp_valid;
   logic                   rsp_ready;
   mlqs_pkg::rsp_word_type rsp_word;

   multilevel_queue_scheduler u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   // Scheduler state kept by the predictor.
   typedef struct {
      int unsigned lvl, id, arr, total, cpu_len, io_len, slc;
      bit          arrived, started;
      int unsigned resp, executed, burst_run, io_run, slice_run;
   } task_entry_type;

   task_entry_type task_table [NumSlots];
   int unsigned sched_time, task_count, dispatches, cpu_slot;
   bit          cpu_busy;
   int unsigned level_queue [NumLevels][$];
   int unsigned io_queue [$];

   mlqs_pkg::req_word_type pending_words [$];
   mlqs_pkg::rsp_word_type expected_words [$];
   int           mismatches;
   bit           stimulus_done = 1'b0;
   int           idle_cycles;

   // Clock and reset.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned at_least_one(int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic void push_ready(int unsigned lv, int unsigned s);
      if (level_queue[lv].size() < NumSlots) level_queue[lv] = {level_queue[lv], s};
   endfunction

   // Computes the result word of one accepted request and updates the scheduler state.
   function automatic mlqs_pkg::rsp_word_type schedule_word(mlqs_pkg::req_word_type w);
      mlqs_pkg::rsp_word_type r;
      int unsigned  cur, s, lv, tt;
      r = '0;
      if (w.command == mlqs_pkg::CmdLoad) begin
         if (task_count >= NumSlots) begin
            r.load_rejected = 1'b1;
         end else begin
            task_table[task_count] = '{default: 0};
            lv = w.level;
            task_table[task_count].lvl = (lv >= NumLevels) ? NumLevels - 1 : lv;
            task_table[task_count].id = w.proc_id;
            task_table[task_count].arr = w.arrival;
            task_table[task_count].total = at_least_one(w.burst_total);
            task_table[task_count].cpu_len = at_least_one(w.cpu_burst_len);
            task_table[task_count].io_len = at_least_one(w.io_len);
            task_table[task_count].slc = at_least_one(w.slice);
            task_count++;
         end
      end else begin
         cur = sched_time;
         // Advance the running task and the I/O head.
         if (cpu_busy) begin
            task_table[cpu_slot].executed++;
            task_table[cpu_slot].burst_run++;
            task_table[cpu_slot].slice_run++;
         end
         if (io_queue.size() != 0) task_table[io_queue[0]].io_run++;
         // Admit arrivals in load order.
         for (int i = 0; i < task_count; i++) begin
            if (!task_table[i].arrived && task_table[i].arr <= cur) begin
               task_table[i].arrived = 1'b1;
               push_ready(task_table[i].lvl, i);
            end
         end
         // Retire, park in I/O or requeue the running task.
         if (cpu_busy) begin
            s = cpu_slot;
            if (task_table[s].executed == task_table[s].total) begin
               tt = (cur >= task_table[s].arr) ? cur - task_table[s].arr : 0;
               r.finish_valid = 1'b1;
               r.finish_id = 8'(task_table[s].id);
               r.turnaround = 16'(tt);
               r.response = 16'(task_table[s].resp);
               r.waiting = 16'((tt >= task_table[s].total) ? tt - task_table[s].total : 0);
               cpu_busy = 1'b0;
            end else if (task_table[s].burst_run == task_table[s].cpu_len) begin
               task_table[s].burst_run = 0;
               task_table[s].io_run = 0;
               task_table[s].slice_run = 0;
               if (io_queue.size() < NumSlots) io_queue = {io_queue, s};
               cpu_busy = 1'b0;
            end else if (task_table[s].slice_run == task_table[s].slc) begin
               task_table[s].slice_run = 0;
               push_ready(task_table[s].lvl, s);
               cpu_busy = 1'b0;
            end
         end
         // Return finished I/O work to its level.
         if (io_queue.size() != 0) begin
            s = io_queue[0];
            if (task_table[s].io_run == task_table[s].io_len) begin
               task_table[s].burst_run = 0;
               task_table[s].slice_run = 0;
               void'(io_queue.pop_front());
               push_ready(task_table[s].lvl, s);
            end
         end
         // Dispatch from the highest non-empty level.
         if (!cpu_busy) begin
            for (int l = NumLevels - 1; l >= 0; l--) begin
               if (level_queue[l].size() != 0) begin
                  s = level_queue[l].pop_front();
                  cpu_busy = 1'b1;
                  cpu_slot = s;
                  if (dispatches < 16'hFFFF) dispatches++;
                  if (!task_table[s].started) begin
                     task_table[s].started = 1'b1;
                     task_table[s].resp = (cur >= task_table[s].arr) ?
                                          cur - task_table[s].arr : 0;
                  end
                  break;
               end
            end
         end
         if (sched_time < 16'hFFFF) sched_time++;
      end
      r.running_valid = cpu_busy;
      r.running_id = cpu_busy ? 8'(task_table[cpu_slot].id) : 8'd0;
      r.context_switches = 16'((dispatches > 0) ? dispatches - 1 : 0);
      return r;
   endfunction

   function automatic mlqs_pkg::req_word_type load_word(int unsigned lv, int unsigned arr,
                                                        int unsigned tot, int unsigned cl,
                                                        int unsigned il, int unsigned sl);
      mlqs_pkg::req_word_type w;
      w.command = mlqs_pkg::CmdLoad;
      w.level = 2'(lv);
      w.proc_id = 8'($urandom_range(255));
      w.arrival = 16'(arr);
      w.burst_total = 16'(tot);
      w.cpu_burst_len = 8'(cl);
      w.io_len = 8'(il);
      w.slice = 8'(sl);
      return w;
   endfunction

   function automatic mlqs_pkg::req_word_type tick_word();
      mlqs_pkg::req_word_type w;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      w = raw[$bits(mlqs_pkg::req_word_type)-1:0];
      w.command = mlqs_pkg::CmdTick;
      return w;
   endfunction

   // Stimulus: directed extremes, then random scenarios of loads followed by ticks.
   initial begin
      int n;
      int tcount;
      mlqs_pkg::req_word_type w;
      // Directed: extreme fields, out-of-range level, zero lengths, table full.
      pending_words = {pending_words, load_word(3, 0, 0, 0, 0, 0)};
      pending_words = {pending_words, load_word(2, 0, 3, 1, 1, 1)};
      pending_words = {pending_words, load_word(0, 1, 4, 2, 255, 255)};
      pending_words = {pending_words, load_word(1, 65535, 65535, 255, 2, 3)};
      pending_words = {pending_words, load_word(1, 2, 5, 3, 1, 2)};
      pending_words = {pending_words, load_word(0, 0, 2, 255, 3, 1)};
      for (int i = 0; i < 12; i++) pending_words = {pending_words, tick_word()};
      pending_words = {pending_words, load_word(2, 3, 2, 1, 1, 1)};
      pending_words = {pending_words, load_word(0, 4, 1, 1, 1, 1)};
      w = load_word(1, 0, 1, 1, 1, 1);
      w.proc_id = 8'hFF;
      pending_words = {pending_words, w};
      pending_words = {pending_words, w};
      for (int i = 0; i < 4; i++) pending_words = {pending_words, tick_word()};
      // Random scenarios; reset is never reapplied, so the table fills and stays full
      // and later scenarios exercise rejection and the long-running schedule.
      n = pending_words.size();
      while (n < 1950) begin
         for (int i = 0; i < $urandom_range(3); i++) begin
            w = load_word($urandom_range(3), sched_time + $urandom_range(20),
                          $urandom_range(12), $urandom_range(6), $urandom_range(5),
                          $urandom_range(6));
            if ($urandom_range(15) == 0) w = tick_word();
            w.command = mlqs_pkg::CmdLoad;
            pending_words = {pending_words, w};
            n++;
         end
         tcount = $urandom_range(40, 5);
         for (int i = 0; i < tcount; i++) begin
            pending_words = {pending_words, tick_word()};
            n++;
         end
      end
      // Time saturation would need 65535 ticks and is not reached; arrival 65535 only tests the field extreme.
      stimulus_done = 1'b1;
   end

   // Driver: bursts of random length with random gaps.
   int burst_left, gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_word <= pending_words.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(12);
               gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(20);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The prediction is made when the word is accepted.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_words = {expected_words, schedule_word(req_word)};
   end

   // Receiver stall pattern: phases of always-ready and random stalls.
   int stall_phase;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase[8]) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(3) != 0);
      end
   end

   // Monitor: compare each result word with the oldest expectation.
   always @(posedge clock) begin
      mlqs_pkg::rsp_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word %h", rsp_word);
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_word !== exp_w) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, got %p", exp_w, rsp_word);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word or taken result.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Reset and end of run.
   initial begin
      mismatches = 0;
      idle_cycles = 0;
      sched_time = 0;
      task_count = 0;
      dispatches = 0;
      cpu_slot = 0;
      cpu_busy = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && pending_words.size() == 0 && !req_valid);
      wait (expected_words.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
